[src/tsrr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrr_pkg
// Types, codes and helpers shared by the task slot round-robin manager.
// ----------------------------------------------------------------------------
package tsrr_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W     = 6;
    localparam int CTX_REGS   = 18;
    localparam int CTX_DEPTH  = SLOT_COUNT * CTX_REGS;
    localparam int CTX_AW     = $clog2(CTX_DEPTH);
    localparam int WORD_W     = 64;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [SLOT_W-1:0] COUNT_MAX = 6'd63;

    // request codes
    localparam logic [2:0] REQ_CREATE = 3'd0;
    localparam logic [2:0] REQ_QUIT   = 3'd1;
    localparam logic [2:0] REQ_SAVE   = 3'd2;
    localparam logic [2:0] REQ_SWITCH = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    // status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_SLOT  = 2'd1;
    localparam logic [1:0] ST_NO_SWTCH = 2'd2;

    // context register indexes
    localparam logic [4:0] CTX_RIP = 5'd0;
    localparam logic [4:0] CTX_CR3 = 5'd1;
    localparam logic [4:0] CTX_RSP = 5'd9;
    localparam logic [4:0] CTX_LIM = 5'd18;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [5:0]        slot;
        logic [4:0]        reg_index;
        logic [WORD_W-1:0] reg_value;
        logic [WORD_W-1:0] start_rip;
        logic [WORD_W-1:0] page_root_in;
        logic [WORD_W-1:0] stack_top;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [5:0]        slot_out;
        logic [WORD_W-1:0] page_root_out;
        logic [WORD_W-1:0] reg_out;
        logic [5:0]        task_count;
    } rsp_t;

    // slot * 18 + reg, as shifts and adds
    function automatic logic [CTX_AW-1:0] ctx_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [4:0] r);
        ctx_addr = CTX_AW'({s, 4'b0000}) + CTX_AW'({s, 1'b0}) + CTX_AW'(r);
    endfunction

endpackage

[src/task_slot_round_robin_manager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_slot_round_robin_manager
// Task slot table with create, quit, context save/read and round-robin switch.
// ----------------------------------------------------------------------------
// the slot scan checks one slot per cycle and the context memory takes one
// access per cycle. one item at a time: req_ready only when idle.
// reset: all slots free, current slot 0, task count 0, kernel base 0; the
// context memory is not cleared.
module task_slot_round_robin_manager
    import tsrr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,
    input  logic              cfg_we,
    input  logic [WORD_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CRT_SCAN,
        S_CRT_RIP,
        S_CRT_CR3,
        S_CRT_RSP,
        S_SW_SCAN,
        S_RD_ISSUE,
        S_RD_DATA,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOT_COUNT-1:0] in_use_reg, in_use_next;
    logic [SLOT_W-1:0]   cur_reg, cur_next;
    logic [SLOT_W-1:0]   live_reg, live_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [WORD_W-1:0]   kbase_reg;
    logic                rsp_valid_reg, rsp_valid_next;
    req_t                req_reg, req_next;
    rsp_t                res_reg, res_next;
    rsp_t                rsp_reg, rsp_next;
    logic [CTX_AW-1:0]   rd_addr_reg, rd_addr_next;

    logic                mem_we;
    logic [CTX_AW-1:0]   mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [WORD_W-1:0]   mem_rdata;

    tsrr_ctx_mem u_ctx_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_addr_reg),
        .rdata (mem_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        in_use_next    = in_use_reg;
        cur_next       = cur_reg;
        live_next      = live_reg;
        idx_next       = idx_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rd_addr_next   = rd_addr_reg;
        rsp_valid_next = rsp_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    res_next   = '0;
                    state_next = S_DONE;
                    case (req.req_type)
                        REQ_CREATE:
                        begin
                            idx_next   = SLOT_W'(1);
                            state_next = S_CRT_SCAN;
                        end
                        REQ_QUIT:
                        begin
                            in_use_next[req.slot] = 1'b0;
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - SLOT_W'(1);
                            end
                            cur_next = '0;
                        end
                        REQ_SAVE:
                        begin
                            if (req.reg_index < CTX_LIM)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = ctx_addr(req.slot, req.reg_index);
                                mem_wdata = req.reg_value;
                            end
                        end
                        REQ_SWITCH:
                        begin
                            res_next.status   = ST_NO_SWTCH;
                            res_next.slot_out = cur_reg;
                            // a lone nonzero task keeps running
                            if (!(live_reg == SLOT_W'(1) && cur_reg != '0))
                            begin
                                idx_next   = cur_reg + SLOT_W'(1);
                                state_next = S_SW_SCAN;
                            end
                        end
                        REQ_READ:
                        begin
                            if (req.reg_index < CTX_LIM)
                            begin
                                rd_addr_next = ctx_addr(req.slot, req.reg_index);
                                state_next   = S_RD_ISSUE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CRT_SCAN:
            begin
                if (!in_use_reg[idx_reg])
                begin
                    in_use_next[idx_reg] = 1'b1;
                    if (live_reg != COUNT_MAX)
                    begin
                        live_next = live_reg + SLOT_W'(1);
                    end
                    res_next.slot_out = idx_reg;
                    state_next        = S_CRT_RIP;
                end
                else if (idx_reg == SLOT_LAST)
                begin
                    res_next.status = ST_NO_SLOT;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            S_CRT_RIP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ctx_addr(idx_reg, CTX_RIP);
                mem_wdata  = req_reg.start_rip;
                state_next = S_CRT_CR3;
            end
            S_CRT_CR3:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ctx_addr(idx_reg, CTX_CR3);
                mem_wdata  = req_reg.page_root_in;
                state_next = S_CRT_RSP;
            end
            S_CRT_RSP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ctx_addr(idx_reg, CTX_RSP);
                mem_wdata  = req_reg.stack_top;
                state_next = S_DONE;
            end
            S_SW_SCAN:
            begin
                // current slot itself is checked last, after the wrap
                if (in_use_reg[idx_reg])
                begin
                    cur_next          = idx_reg;
                    res_next.status   = ST_DONE;
                    res_next.slot_out = idx_reg;
                    rd_addr_next      = ctx_addr(idx_reg, CTX_CR3);
                    state_next        = S_RD_ISSUE;
                end
                else if (idx_reg == cur_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            S_RD_ISSUE:
            begin
                mem_re     = 1'b1;
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                if (req_reg.req_type == REQ_SWITCH)
                begin
                    res_next.page_root_out = mem_rdata - kbase_reg;
                end
                else
                begin
                    res_next.reg_out = mem_rdata;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next            = res_reg;
                    rsp_next.task_count = live_reg;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_use_reg    <= '0;
            cur_reg       <= '0;
            live_reg      <= '0;
            idx_reg       <= '0;
            kbase_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_use_reg    <= in_use_next;
            cur_reg       <= cur_next;
            live_reg      <= live_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                kbase_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
        rd_addr_reg <= rd_addr_next;
    end

endmodule

[src/tsrr_ctx_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrr_ctx_mem
// Saved task contexts, 18 words per slot, one write and one read port.
// ----------------------------------------------------------------------------
module tsrr_ctx_mem
    import tsrr_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [CTX_AW-1:0] waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [CTX_AW-1:0] raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem_q [CTX_DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_q[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[tb/tsrr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrr_checker
// Watches the request, result and kernel base ports of the task slot manager,
// predicts every result from its own copy of the slot table and compares it.
// ----------------------------------------------------------------------------
module tsrr_checker
    import tsrr_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  req_t                          req,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  rsp_t                          rsp,
    input  logic                          cfg_we,
    input  logic [WORD_W-1:0]             cfg_data,
    output int unsigned                   mismatches,
    output int unsigned                   awaited,
    output int unsigned                   results,
    output logic [SLOT_COUNT-1:0]         busy_view,
    output logic [SLOT_COUNT*CTX_REGS-1:0] ctx_known
);

    // shadow of the slot table
    logic [SLOT_COUNT-1:0]          in_use;
    logic [SLOT_W-1:0]              cur_slot;
    logic [SLOT_W-1:0]              live;
    logic [WORD_W-1:0]              kbase;
    logic [WORD_W-1:0]              ctx_mem [SLOT_COUNT*CTX_REGS];
    logic [SLOT_COUNT*CTX_REGS-1:0] ctx_mark;
    rsp_t                           result_q [$];

    function automatic rsp_t sched_step(input req_t r);
        rsp_t o;
        int   i;
        int   k;
        int   idx;
        int   start;
        logic hit;
        o   = '0;
        idx = 0;
        hit = 1'b0;
        case (r.req_type)
            REQ_CREATE:
            begin
                for (i = 1; i < SLOT_COUNT; i++)
                    if (idx == 0 && !in_use[i])
                        idx = i;
                if (idx == 0)
                    o.status = ST_NO_SLOT;
                else
                begin
                    in_use[idx] = 1'b1;
                    ctx_mem[idx*CTX_REGS + int'(CTX_RIP)] = r.start_rip;
                    ctx_mem[idx*CTX_REGS + int'(CTX_CR3)] = r.page_root_in;
                    ctx_mem[idx*CTX_REGS + int'(CTX_RSP)] = r.stack_top;
                    ctx_mark[idx*CTX_REGS + int'(CTX_RIP)] = 1'b1;
                    ctx_mark[idx*CTX_REGS + int'(CTX_CR3)] = 1'b1;
                    ctx_mark[idx*CTX_REGS + int'(CTX_RSP)] = 1'b1;
                    if (live < COUNT_MAX)
                        live = live + 6'd1;
                    o.slot_out = idx[SLOT_W-1:0];
                end
            end
            REQ_QUIT:
            begin
                if (int'(r.slot) < SLOT_COUNT)
                    in_use[r.slot] = 1'b0;
                if (live != '0)
                    live = live - 6'd1;
                cur_slot = '0;
            end
            REQ_SAVE:
            begin
                if (int'(r.slot) < SLOT_COUNT && r.reg_index < CTX_LIM)
                begin
                    ctx_mem[int'(r.slot)*CTX_REGS + int'(r.reg_index)]  = r.reg_value;
                    ctx_mark[int'(r.slot)*CTX_REGS + int'(r.reg_index)] = 1'b1;
                end
            end
            REQ_SWITCH:
            begin
                o.status   = ST_NO_SWTCH;
                o.slot_out = cur_slot;
                // a lone task that is already current stays put
                if (!(live == 6'd1 && cur_slot != '0))
                begin
                    start = int'(cur_slot);
                    for (k = 1; k <= SLOT_COUNT; k++)
                    begin
                        i = (start + k) % SLOT_COUNT;
                        if (!hit && in_use[i])
                        begin
                            hit             = 1'b1;
                            cur_slot        = i[SLOT_W-1:0];
                            o.status        = ST_DONE;
                            o.slot_out      = i[SLOT_W-1:0];
                            o.page_root_out = ctx_mem[i*CTX_REGS + int'(CTX_CR3)] - kbase;
                        end
                    end
                end
            end
            REQ_READ:
            begin
                if (int'(r.slot) < SLOT_COUNT && r.reg_index < CTX_LIM)
                    o.reg_out = ctx_mem[int'(r.slot)*CTX_REGS + int'(r.reg_index)];
            end
            default:
            begin
            end
        endcase
        o.task_count = live;
        return o;
    endfunction

    task automatic check_field(input string what, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch on result %0d, expected %h, got %h",
                     $time, what, results, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        rsp_t want;
        if (!rst_n)
        begin
            in_use   = '0;
            cur_slot = '0;
            live     = '0;
            kbase    = '0;
            ctx_mark = '0;
            for (int n = 0; n < SLOT_COUNT*CTX_REGS; n++)
                ctx_mem[n] = '0;
            result_q.delete();
            mismatches = 0;
            results    = 0;
            awaited   <= 0;
            busy_view <= '0;
            ctx_known <= '0;
        end
        else
        begin
            if (cfg_we)
                kbase = cfg_data;
            if (req_valid && req_ready)
                result_q.push_back(sched_step(req));
            if (rsp_valid && rsp_ready)
            begin
                if (result_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected result, expected none, got %h", $time, rsp);
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("status", WORD_W'(want.status), WORD_W'(rsp.status));
                    check_field("slot_out", WORD_W'(want.slot_out), WORD_W'(rsp.slot_out));
                    check_field("page_root_out", want.page_root_out, rsp.page_root_out);
                    check_field("reg_out", want.reg_out, rsp.reg_out);
                    check_field("task_count", WORD_W'(want.task_count),
                                WORD_W'(rsp.task_count));
                end
                results++;
            end
            // stimulus side sees registered copies of these, which is safe
            awaited   <= result_q.size();
            busy_view <= in_use;
            ctx_known <= ctx_mark;
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives create, quit, save, read and switch requests into the task slot
// manager under random idling and back-pressure, across several kernel base
// settings, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top
    import tsrr_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          PHASE_ITEMS = 80;
    localparam int          FILL_ITEMS  = 70;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    req_t              req       = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    rsp_t              rsp;
    logic              cfg_we    = 1'b0;
    logic [WORD_W-1:0] cfg_data  = '0;

    int unsigned                    mismatches;
    int unsigned                    awaited;
    int unsigned                    results;
    logic [SLOT_COUNT-1:0]          busy_view;
    logic [SLOT_COUNT*CTX_REGS-1:0] ctx_known;

    int unsigned cycles     = 0;
    int unsigned items_sent = 0;
    bit          tx_idle_on = 1'b1;

    task_slot_round_robin_manager i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    tsrr_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaited    (awaited),
        .results    (results),
        .busy_view  (busy_view),
        .ctx_known  (ctx_known)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off, then a stretch always ready
    initial
    begin : result_sink
        int taken;
        int stall_left;
        bit held;
        taken      = 0;
        stall_left = 0;
        held       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                taken++;
            if (!held && taken == 150)
            begin
                held       = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (taken >= 260 && taken < 340)
                rsp_ready <= 1'b1;
            else
                rsp_ready <= ($urandom_range(99) >= 23);
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [SLOT_W-1:0] busy_slot();
        logic [SLOT_W-1:0] s;
        for (int t = 0; t < 64; t++)
        begin
            s = SLOT_W'($urandom);
            if (busy_view[s])
                return s;
        end
        return SLOT_W'($urandom);
    endfunction

    // a read may only touch context words already written
    function automatic req_t shaped_req(input logic [2:0] kind, input bit wild);
        req_t              r;
        logic [SLOT_W-1:0] s;
        logic [4:0]        g;
        bit                found;
        r.req_type     = kind;
        r.slot         = SLOT_W'($urandom);
        r.reg_index    = wild ? 5'($urandom) : 5'($urandom_range(CTX_REGS - 1));
        r.reg_value    = rand_word();
        r.start_rip    = rand_word();
        r.page_root_in = rand_word();
        r.stack_top    = rand_word();
        found          = 1'b0;
        if (!wild && (kind == REQ_QUIT || kind == REQ_SAVE) && $urandom_range(3) != 0)
            r.slot = busy_slot();
        if (!wild && kind == REQ_SAVE && $urandom_range(9) == 0)
            r.reg_index = 5'($urandom_range(31, CTX_REGS));
        if (kind == REQ_READ && r.reg_index < CTX_LIM
            && !ctx_known[int'(r.slot)*CTX_REGS + int'(r.reg_index)])
        begin
            for (int t = 0; t < 64 && !found; t++)
            begin
                s = SLOT_W'($urandom);
                case ($urandom_range(5))
                    0:       g = CTX_RIP;
                    1:       g = CTX_CR3;
                    2:       g = CTX_RSP;
                    default: g = 5'($urandom_range(CTX_REGS - 1));
                endcase
                if (ctx_known[int'(s)*CTX_REGS + int'(g)])
                begin
                    found       = 1'b1;
                    r.slot      = s;
                    r.reg_index = g;
                end
            end
            if (!found)
                r.reg_index = 5'($urandom_range(31, CTX_REGS));
        end
        return r;
    endfunction

    function automatic req_t op_req(input logic [2:0] kind, input logic [SLOT_W-1:0] s,
                                    input logic [4:0] g, input logic [WORD_W-1:0] v);
        req_t r;
        r.req_type     = kind;
        r.slot         = s;
        r.reg_index    = g;
        r.reg_value    = v;
        r.start_rip    = ~v;
        r.page_root_in = v;
        r.stack_top    = v;
        return r;
    endfunction

    // called just after a rising edge; returns at the edge that takes the item
    task automatic send_req(input req_t item);
        int gap;
        gap = 0;
        if (tx_idle_on)
            while ($urandom_range(99) < 23)
                gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited != 0);
    endtask

    task automatic write_base(input logic [WORD_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [WORD_W-1:0] base;
        logic [2:0]        kind;
        bit                wild;
        int                pick;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_base('0);

        // directed: empty table, lone task, wrap, ignored saves and reads
        send_req(op_req(REQ_SWITCH, 6'd0, CTX_RIP, '0));
        send_req(op_req(REQ_QUIT, 6'd5, CTX_RIP, '0));
        send_req(op_req(REQ_CREATE, 6'd0, CTX_RIP, '1));
        send_req(op_req(REQ_CREATE, 6'd63, 5'd31, '0));
        send_req(op_req(REQ_SWITCH, 6'd63, CTX_RIP, '1));
        send_req(op_req(REQ_READ, 6'd1, CTX_CR3, '0));
        send_req(op_req(REQ_READ, 6'd2, CTX_RSP, '1));
        send_req(op_req(REQ_SAVE, 6'd2, CTX_LIM - 5'd1, '1));
        send_req(op_req(REQ_READ, 6'd2, CTX_LIM - 5'd1, '0));
        send_req(op_req(REQ_SAVE, 6'd63, CTX_RIP, 64'h0123_4567_89ab_cdef));
        send_req(op_req(REQ_READ, 6'd63, CTX_RIP, '0));
        send_req(op_req(REQ_SAVE, 6'd2, 5'd31, '1));
        send_req(op_req(REQ_READ, 6'd2, 5'd31, '0));
        send_req(op_req(REQ_READ, 6'd2, CTX_LIM, '0));
        send_req(op_req(REQ_SWITCH, 6'd0, CTX_RIP, '0));
        send_req(op_req(REQ_SWITCH, 6'd0, CTX_RIP, '0));
        send_req(op_req(REQ_QUIT, 6'd2, CTX_RIP, '0));
        send_req(op_req(REQ_SWITCH, 6'd0, CTX_RIP, '0));
        send_req(op_req(REQ_SWITCH, 6'd0, CTX_RIP, '0));
        // quitting a free slot still drops the count, leaving slot 1 alone
        send_req(op_req(REQ_QUIT, 6'd40, CTX_RIP, '0));
        send_req(op_req(REQ_SWITCH, 6'd0, CTX_RIP, '0));
        send_req(op_req(REQ_SWITCH, 6'd0, CTX_RIP, '0));
        for (int c = int'(REQ_READ) + 1; c < 8; c++)
            send_req(shaped_req(c[2:0], 1'b1));
        send_req(op_req(REQ_CREATE, 6'd0, CTX_RIP, 64'h8000_0000_0000_0000));
        send_req(op_req(REQ_QUIT, 6'd0, CTX_RIP, '0));

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0:       base = '1;
                2:       base = 64'h8000_0000_0000_0000;
                4:       base = 64'd1;
                5:       base = '0;
                default: base = {$urandom, $urandom};
            endcase
            write_base(base);
            tx_idle_on = (ph != 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                wild = 1'b0;
                pick = $urandom_range(99);
                // fill the table once so that create runs out of slots
                if (ph == 1 && n < FILL_ITEMS)
                    kind = REQ_CREATE;
                else if (pick < 22)
                    kind = ($countones(busy_view) > 45 && $urandom_range(1) == 0)
                           ? REQ_QUIT : REQ_CREATE;
                else if (pick < 40)
                    kind = REQ_SAVE;
                else if (pick < 65)
                    kind = REQ_SWITCH;
                else if (pick < 83)
                    kind = REQ_READ;
                else if (pick < 95)
                    kind = REQ_QUIT;
                else
                begin
                    kind = 3'($urandom_range(7));
                    wild = 1'b1;
                end
                send_req(shaped_req(kind, wild));
            end
        end

        drain();
        repeat (80) @(posedge clk);
        $display("covered %0d requests and %0d checked results over seven kernel base settings",
                 items_sent, results);
        if (mismatches == 0 && awaited == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
